[sv/assert_macros.svh]
// Assertion macros shared by the short key hash modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define SHK_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the following cycle.
`define SHK_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

[sv/shk_pkg.sv]
// Constants, types and helper functions of the short key hash.
package shk_pkg;

  localparam logic [31:0] SEED_A = 32'd1192827283;
  localparam logic [31:0] SEED_B = 32'd534897851;
  localparam logic [31:0] PRIME1 = 32'd2654435761;
  localparam logic [31:0] PRIME2 = 32'd2246822519;
  localparam logic [31:0] PRIME3 = 32'd3266489917;
  localparam logic [31:0] PRIME4 = 32'd668265263;
  localparam logic [31:0] PRIME5 = 32'd374761393;

  localparam logic [1:0] MODE_A    = 2'd0;
  localparam logic [1:0] MODE_B    = 2'd1;
  localparam logic [1:0] MODE_ZERO = 2'd2;

  localparam int unsigned KEY_W     = 64;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned HASH_W    = 32;
  localparam int unsigned IN_DATA_W = 72;

  localparam logic [LEN_W-1:0] LEN_MAX = 4'd8;
  localparam logic [LEN_W-1:0] LEN_HI  = 4'd4;

  // Result of the mixing pipe handed to the finishing pipe.
  typedef struct packed {
    logic        long_key;
    logic [31:0] acc_hi;
    logic [31:0] acc_lo;
  } mix_t;

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  function automatic logic [31:0] rotl17(input logic [31:0] x);
    return {x[14:0], x[31:15]};
  endfunction

endpackage

[sv/shk_mix.sv]
// Three-stage pipe that masks the key and mixes in its high and low words.
`include "assert_macros.svh"

module shk_mix
  import shk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KEY_W-1:0]      in_key,
  input  logic [LEN_W-1:0]      in_len,
  input  logic [MODE_W-1:0]     in_mode,
  output logic                  mix_valid,
  input  logic                  mix_ready,
  output mix_t                  mix_data
);

  logic [LEN_W-1:0] len_sat;
  logic [KEY_W-1:0] key_masked;
  logic [31:0]      seed;
  logic [31:0]      mult;

  // Stage 1: start value, high word product.
  logic        s1_v_r;
  logic [31:0] s1_h_r, s1_mhi_r, s1_lo_r, s1_mult_r;
  logic        s1_long_r;
  // Stage 2: high word mixed, low word product.
  logic        s2_v_r;
  logic [31:0] s2_acc_r, s2_mlo_r;
  logic        s2_long_r;
  // Stage 3: low word mixed.
  logic        s3_v_r;
  mix_t        s3_r;

  logic s1_rdy, s2_rdy, s3_rdy;

  assign s3_rdy   = !s3_v_r || mix_ready;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  always_comb begin
    len_sat = (in_len > LEN_MAX) ? LEN_MAX : in_len;
    for (int i = 0; i < 8; i++) begin
      // Byte i counted from the bottom is kept when it lies in the top len bytes.
      if ((5'(i) + {1'b0, len_sat}) >= 5'd8) begin
        key_masked[8*i +: 8] = in_key[8*i +: 8];
      end else begin
        key_masked[8*i +: 8] = 8'd0;
      end
    end
    case (in_mode)
      MODE_A: begin
        seed = SEED_A;
        mult = PRIME1;
      end
      MODE_B: begin
        seed = SEED_B;
        mult = PRIME3;
      end
      MODE_ZERO: begin
        seed = 32'd0;
        mult = PRIME3;
      end
      default: begin
        seed = 32'd0;
        mult = PRIME3;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= in_valid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_rdy) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_h_r    <= PRIME5 + seed + {28'd0, len_sat};
      s1_mhi_r  <= mul32(key_masked[63:32], mult);
      s1_lo_r   <= key_masked[31:0];
      s1_mult_r <= mult;
      s1_long_r <= (len_sat > LEN_HI);
    end
    if (s2_rdy && s1_v_r) begin
      s2_acc_r  <= mul32(rotl17(s1_h_r ^ s1_mhi_r), PRIME4);
      s2_mlo_r  <= mul32(s1_lo_r, s1_mult_r);
      s2_long_r <= s1_long_r;
    end
    if (s3_rdy && s2_v_r) begin
      s3_r.acc_hi   <= s2_acc_r;
      s3_r.acc_lo   <= mul32(rotl17(s2_acc_r ^ s2_mlo_r), PRIME4);
      s3_r.long_key <= s2_long_r;
    end
  end

  assign mix_valid = s3_v_r;
  assign mix_data  = s3_r;

  // A nonzero low word survives masking only for keys longer than four bytes.
  `SHK_ASSERT_NOW(a_lo_needs_long, s1_v_r && (s1_lo_r != 32'd0), s1_long_r, "low word kept for short key")
  // A stalled first stage keeps its item.
  `SHK_ASSERT_NEXT(a_s1_hold, s1_v_r && !s2_rdy, s1_v_r && $stable(s1_h_r) && $stable(s1_mhi_r), "stage 1 lost data under stall")

endmodule

[sv/shk_final.sv]
// Three-stage avalanche pipe ending in the output register.
`include "assert_macros.svh"

module shk_final
  import shk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              mix_valid,
  output logic              mix_ready,
  input  mix_t              mix_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HASH_W-1:0] out_hash
);

  logic [31:0] x;

  logic        s4_v_r, s5_v_r, s6_v_r;
  logic [31:0] s4_r, s5_r, s6_r;
  logic        s4_rdy, s5_rdy, s6_rdy;

  assign s6_rdy    = !s6_v_r || out_ready;
  assign s5_rdy    = !s5_v_r || s6_rdy;
  assign s4_rdy    = !s4_v_r || s5_rdy;
  assign mix_ready = s4_rdy;

  assign x = mix_data.long_key ? mix_data.acc_lo : mix_data.acc_hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else begin
      if (s4_rdy) begin
        s4_v_r <= mix_valid;
      end
      if (s5_rdy) begin
        s5_v_r <= s4_v_r;
      end
      if (s6_rdy) begin
        s6_v_r <= s5_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s4_rdy && mix_valid) begin
      s4_r <= mul32(x ^ (x >> 15), PRIME2);
    end
    if (s5_rdy && s4_v_r) begin
      s5_r <= mul32(s4_r ^ (s4_r >> 13), PRIME3);
    end
    if (s6_rdy && s5_v_r) begin
      s6_r <= s5_r ^ (s5_r >> 16);
    end
  end

  assign out_valid = s6_v_r;
  assign out_hash  = s6_r;

  // A stalled first avalanche stage keeps its item.
  `SHK_ASSERT_NEXT(a_s4_hold, s4_v_r && !s5_rdy, s4_v_r && $stable(s4_r), "stage 4 lost data under stall")

endmodule

[sv/short_key_mix_hash_top.sv]
// Top level of the short key hash: a six-stage pipeline from key word to hash word.
//
// Usage: each input word carries a 64-bit key, the number of significant key
// bytes counted from the top byte (1 to 8; larger values act as 8) and a mode
// on in_tuser that picks the seed and multiplier of one of three variants
// (mode 3 acts as mode 2). A word is accepted when in_tvalid and in_tready are
// both high; one hash word comes out on the out_ channel for every input word,
// in order.
//
// Throughput is one word per cycle while out_tready is high: no stage chains
// more than one 32x32 multiply, so a new key can enter every cycle. Each stage
// has its own valid bit and advances when the stage after it is empty or
// moving, so bubbles close up under backpressure.
//
// When out_tready is low the result holds in the output register while the
// earlier stages keep filling; in_tready drops only once all six stages are
// full. Reset (rst_n low, synchronous) empties the pipeline; the block keeps
// no other state.
module short_key_mix_hash_top
  import shk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // [63:0] key, [67:64] key_length, [71:68] zero
  input  logic [MODE_W-1:0]    in_tuser,   // [1:0] mode
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [HASH_W-1:0]    out_tdata   // [31:0] hash
);

  logic mix_valid;
  logic mix_ready;
  mix_t mix_data;

  // Masking, start value and word mixing.
  shk_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_key    (in_tdata[63:0]),
    .in_len    (in_tdata[67:64]),
    .in_mode   (in_tuser),
    .mix_valid (mix_valid),
    .mix_ready (mix_ready),
    .mix_data  (mix_data)
  );

  // Word selection and the avalanche, ending in the output register.
  shk_final u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .mix_valid (mix_valid),
    .mix_ready (mix_ready),
    .mix_data  (mix_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_hash  (out_tdata)
  );

endmodule

[verif/tb_short_key_mix_hash_top.sv]
// Self-checking testbench for the short key hash pipeline top level.
`timescale 1ns / 1ps

module tb_short_key_mix_hash_top;
  import shk_pkg::*;

  // Mode 3 has no name in the package; the block treats it as the zero-seed
  // variant, and the stimulus uses it on purpose.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // One accepted key word, together with the hash that the pipe must return.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  key_length;
    logic [MODE_W-1:0] mode;
    logic [HASH_W-1:0] hash;
  } hash_job_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;    // [63:0] key, [67:64] key_length, [71:68] zero
  logic [MODE_W-1:0]    in_tuser = '0;    // [1:0] mode
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [HASH_W-1:0]    out_tdata;        // [31:0] hash

  // Hashes that have been launched into the pipe and are still owed, oldest first.
  hash_job_t   pending_hashes[$];
  int unsigned mismatch_count = 0;

  // Chance, in percent, that the key sender or the hash receiver idles in a cycle.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  short_key_mix_hash_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One round of multiply, rotate by 17 and multiply, folding a 32-bit word
  // into the accumulator. All products keep only their low 32 bits.
  function automatic logic [31:0] fold_word(input logic [31:0] acc,
                                            input logic [31:0] word,
                                            input logic [31:0] mult);
    logic [31:0] mixed;
    mixed = acc ^ (word * mult);
    mixed = (mixed << 17) | (mixed >> 15);
    return mixed * PRIME4;
  endfunction

  // Expected hash of one key word. The length saturates at eight bytes, only
  // the top bytes of the key survive, and the low word only counts for keys
  // longer than four bytes. Length zero clears the whole key.
  function automatic logic [31:0] predict_hash(input logic [KEY_W-1:0]  key,
                                               input logic [LEN_W-1:0]  key_length,
                                               input logic [MODE_W-1:0] mode);
    logic [LEN_W-1:0] nbytes;
    logic [63:0]      kept;
    logic [31:0]      seed;
    logic [31:0]      mult;
    logic [31:0]      acc;
    nbytes = (key_length > LEN_MAX) ? LEN_MAX : key_length;
    if (nbytes == 0) begin
      kept = '0;
    end else begin
      kept = key & ({64{1'b1}} << ((8 - nbytes) * 8));
    end
    case (mode)
      MODE_A: begin
        seed = SEED_A;
        mult = PRIME1;
      end
      MODE_B: begin
        seed = SEED_B;
        mult = PRIME3;
      end
      default: begin
        seed = '0;
        mult = PRIME3;
      end
    endcase
    acc = PRIME5 + seed + {28'd0, nbytes};
    acc = fold_word(acc, kept[63:32], mult);
    if (nbytes > LEN_HI) begin
      acc = fold_word(acc, kept[31:0], mult);
    end
    // Avalanche.
    acc = acc ^ (acc >> 15);
    acc = acc * PRIME2;
    acc = acc ^ (acc >> 13);
    acc = acc * PRIME3;
    acc = acc ^ (acc >> 16);
    return acc;
  endfunction

  // The receiver drops out_tready at random. Being a single nonblocking
  // assignment per edge, it never races with itself.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every hash word that leaves the pipe is compared with the oldest owed hash.
  // Sampling at the edge sees the values from before the edge, as the
  // handshake itself does.
  always @(posedge clk) begin
    hash_job_t job;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_hashes.size() == 0) begin
        $display("%0t: unexpected hash word %h with nothing owed", $time, out_tdata);
        mismatch_count++;
      end else begin
        job = pending_hashes.pop_front();
        if (out_tdata !== job.hash) begin
          $display("%0t: hash mismatch for key %h length %0d mode %0d: expected %h, got %h",
                   $time, job.key, job.key_length, job.mode, job.hash, out_tdata);
          mismatch_count++;
        end
      end
    end
  end

  // Offers one key word and returns at the edge at which it is taken. The
  // valid is left high on return; the next call either keeps it up with a new
  // word or drops it while it idles, so it is assigned at most once per edge.
  task automatic send_key(input logic [KEY_W-1:0]  key,
                          input logic [LEN_W-1:0]  key_length,
                          input logic [MODE_W-1:0] mode);
    hash_job_t job;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, key_length, key};
    in_tuser  <= mode;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    job.key        = key;
    job.key_length = key_length;
    job.mode       = mode;
    job.hash       = predict_hash(key, key_length, mode);
    pending_hashes.push_back(job);
  endtask

  // Stops sending and waits until every owed hash has come back, then idles on
  // so that a stray extra word would still be caught.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_hashes.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
  endtask

  // Field extremes, each length class and each mode, including the unused mode,
  // a length of zero and lengths above eight.
  task automatic test_directed();
    logic [LEN_W-1:0] lengths[7];
    lengths = '{4'd0, 4'd1, 4'd4, 4'd5, 4'd8, 4'd9, 4'd15};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (lengths[i]) begin
      send_key({64{1'b1}}, lengths[i], MODE_A);
      send_key(64'h0123_4567_89ab_cdef, lengths[i], MODE_B);
    end
    send_key('0, LEN_MAX, MODE_A);
    send_key('0, LEN_MAX, MODE_B);
    send_key('0, LEN_MAX, MODE_ZERO);
    send_key('0, LEN_MAX, MODE_SPARE);
    send_key(64'haaaa_aaaa_aaaa_aaaa, 4'd3, MODE_ZERO);
    send_key(64'h5555_5555_5555_5555, 4'd6, MODE_SPARE);
    send_key(64'h8000_0000_0000_0001, LEN_MAX, MODE_ZERO);
    send_key(64'hfedc_ba98_7654_3210, 4'd7, MODE_SPARE);
    wait_drained();
  endtask

  // A burst into a stalled receiver, then a full pause of the sender until the
  // pipe has emptied, then a second burst.
  task automatic test_pause_until_drained();
    send_idle_pct = 0;
    recv_idle_pct = 90;
    repeat (20) begin
      send_key({$urandom, $urandom}, LEN_W'($urandom_range(8, 1)),
               MODE_W'($urandom_range(3)));
    end
    wait_drained();
    recv_idle_pct = 0;
    repeat (20) begin
      send_key({$urandom, $urandom}, LEN_W'($urandom_range(8, 1)),
               MODE_W'($urandom_range(3)));
    end
    wait_drained();
  endtask

  // Random key words: mostly legal lengths, some on the four and eight byte
  // boundaries, some zero or above eight, and now and then a degenerate key.
  task automatic test_random(input int unsigned count,
                             input int unsigned sender_idle,
                             input int unsigned receiver_idle);
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] key_length;
    int unsigned      pick;
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        key_length = LEN_W'($urandom_range(8, 1));
      end else if (pick < 88) begin
        case ($urandom_range(3))
          0: key_length = 4'd1;
          1: key_length = LEN_HI;
          2: key_length = LEN_HI + 4'd1;
          default: key_length = LEN_MAX;
        endcase
      end else begin
        key_length = LEN_W'($urandom_range(15));
      end
      pick = $urandom_range(19);
      if (pick == 0) begin
        key = '0;
      end else if (pick == 1) begin
        key = {64{1'b1}};
      end else if (pick == 2) begin
        key = 64'd1 << $urandom_range(63);
      end else begin
        key = {$urandom, $urandom};
      end
      send_key(key, key_length, MODE_W'($urandom_range(3)));
    end
    wait_drained();
  endtask

  // Run sequence: reset, the directed words, the pause test, then three random
  // phases with the idling shifted from receiver to sender and finally switched
  // off.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pause_until_drained();
    test_random(240, 8, 60);
    test_random(240, 60, 8);
    test_random(240, 0, 0);
    if (mismatch_count == 0 && pending_hashes.size() == 0) begin
      $display("short_key_mix_hash_top test passed");
    end else begin
      $display("short_key_mix_hash_top test failed");
    end
    $finish;
  end

  // Watchdog: fires far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("short_key_mix_hash_top test failed");
    $finish;
  end

endmodule
